// ----- hw/rtl/eert_pkg.sv -----
package eert_pkg;

   localparam int TableEntriesDefault = 64;
   localparam int VapCountDefault     = 16;
   localparam int CounterBitsDefault  = 32;
   localparam logic [7:0] TimeoutReset = 8'd2;

   localparam logic [1:0] CMD_EAP   = 2'd0;
   localparam logic [1:0] CMD_SWEEP = 2'd1;

   localparam logic [1:0] CODE_REQUEST  = 2'd0;
   localparam logic [1:0] CODE_RESPONSE = 2'd1;
   localparam logic [1:0] CODE_SUCCESS  = 2'd2;
   localparam logic [1:0] CODE_FAILURE  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_REPORT,
      ST_OUTPUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_step;
      logic update;
      logic report;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_eap;
      logic is_sweep;
      logic scan_last;
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  vap_index;
      logic [47:0] station_mac;
      logic [1:0]  eap_code;
      logic [7:0]  eap_identifier;
      logic [1:0]  direction;
      logic [31:0] current_seconds;
   } req_word_type;

   typedef struct packed {
      logic [31:0] success_count;
      logic [31:0] failure_count;
      logic [31:0] timeout_count;
      logic [31:0] retry_count;
      logic        retry_seen;
      logic        table_full;
      logic [6:0]  expired_now;
   } rsp_word_type;

   // Contents of one slot of the exchange table, apart from its valid bit.
   typedef struct packed {
      logic [3:0]  vap;
      logic [47:0] mac;
      logic        is_response;
      logic [7:0]  identifier;
      logic [1:0]  direction;
      logic [31:0] stamp;
   } slot_entry_type;

endpackage

// ----- hw/rtl/eert_req_if.sv -----
interface eert_req_if;
   import eert_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/eert_rsp_if.sv -----
interface eert_rsp_if;
   import eert_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/eap_exchange_retry_tracker_core.sv -----
// EAP exchange retry tracker.
// req channel: one word per EAP frame, timeout sweep or ignored EAPOL frame.
// rsp channel: exactly one word per request word, carrying the four counters
// of the named access point and the retry, table-full and expiry flags.
// csr port: csr_write_enable with csr_write_data sets the timeout in seconds
// (reset value 2); write only while the block is idle.
// After a word is taken, the slot walk reads one table entry per cycle
// through the slot memory for an EAP frame or a sweep, and an EAP frame
// then has an update step; an ignored frame or an access point out of
// range skips both. One word is in work at a time, and the next can be
// taken in the same cycle as the result appears.
// Reset clears all slot valid bits and all counters; the slot memory
// itself is not cleared, as an entry is only read while it is valid.
// When the receiver stalls, the finished word waits in the output register;
// the next word is still taken and worked on, but its result waits in the
// report stage and no further word is taken until the output register frees.
module eap_exchange_retry_tracker_core #(
   parameter int TABLE_ENTRIES = eert_pkg::TableEntriesDefault,
   parameter int VAP_COUNT     = eert_pkg::VapCountDefault,
   parameter int COUNTER_BITS  = eert_pkg::CounterBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   eert_req_if.sink   req,
   eert_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import eert_pkg::*;

   logic [7:0] timeout_ff;
   cmd_type    cmd;
   status_type status;

   // Timeout register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TimeoutReset;
      end else if (csr_write_enable) begin
         timeout_ff <= csr_write_data;
      end
   end

   eert_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   eert_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .VAP_COUNT     (VAP_COUNT),
      .COUNTER_BITS  (COUNTER_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .timeout_seconds (timeout_ff),
      .req_data        (req.data),
      .cmd             (cmd),
      .status          (status),
      .rsp_data        (rsp.data)
   );

`ifndef SYNTHESIS
   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid)
      else $error("result withdrawn before it was taken");
   // A result that is not taken keeps its word.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(rsp.data))
      else $error("result word changed while waiting");
   // A retry always finds its own slot, so it never meets a full table.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.data.retry_seen && rsp.data.table_full))
      else $error("retry and full flagged together");
`endif
endmodule

// ----- hw/rtl/eert_ctrl.sv -----
module eert_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  eert_pkg::status_type status,
   output eert_pkg::cmd_type    cmd
);
   import eert_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.is_eap && !status.is_sweep) begin
               state_in = ST_REPORT;
            end else if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = status.is_eap ? ST_UPDATE : ST_REPORT;
         end
         ST_UPDATE: state_in = ST_REPORT;
         ST_REPORT: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output valid register: loaded when the result is handed over.
   always_comb begin
      rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);
   end

   // Commands.
   always_comb begin
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load       = req_valid;
            cmd.scan_clear = req_valid;
         end
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_DRAIN:  cmd           = '0;
         ST_UPDATE: cmd.update    = 1'b1;
         ST_REPORT: cmd.report    = 1'b1;
         ST_OUTPUT: cmd.emit      = !rsp_valid_ff || rsp_ready;
         default:   cmd           = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ----- hw/rtl/eert_dp.sv -----
module eert_dp #(
   parameter int TABLE_ENTRIES = eert_pkg::TableEntriesDefault,
   parameter int VAP_COUNT     = eert_pkg::VapCountDefault,
   parameter int COUNTER_BITS  = eert_pkg::CounterBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             timeout_seconds,
   input  eert_pkg::req_word_type req_data,
   input  eert_pkg::cmd_type      cmd,
   output eert_pkg::status_type   status,
   output eert_pkg::rsp_word_type rsp_data
);
   import eert_pkg::*;

   localparam int IdxBits = $clog2(TABLE_ENTRIES);
   localparam int VapBits = (VAP_COUNT > 1) ? $clog2(VAP_COUNT) : 1;

   // Slot table: valid bits in flip-flops, the slot contents in a memory.
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   slot_entry_type           slot_mem [TABLE_ENTRIES];

   logic [COUNTER_BITS-1:0] succ_ff [VAP_COUNT];
   logic [COUNTER_BITS-1:0] fail_ff [VAP_COUNT];
   logic [COUNTER_BITS-1:0] tout_ff [VAP_COUNT];
   logic [COUNTER_BITS-1:0] rtry_ff [VAP_COUNT];

   req_word_type       item_ff;
   logic [IdxBits-1:0] addr_ff;
   slot_entry_type     rd_ff;
   logic               rd_valid_ff, rd_live_ff;
   logic [IdxBits-1:0] rd_idx_ff;
   logic               hit_ff, free_ok_ff;
   logic [IdxBits-1:0] hit_idx_ff, free_idx_ff;
   logic               hit_resp_ff;
   logic [7:0]         hit_ident_ff;
   logic [1:0]         hit_dir_ff;
   logic               retry_ff, full_ff;
   logic [6:0]         expired_ff;
   rsp_word_type       out_ff;

   logic vap_ok;
   assign vap_ok = ({28'd0, item_ff.vap_index} < 32'(VAP_COUNT));

   assign status.is_eap    = (item_ff.command == CMD_EAP) && vap_ok;
   assign status.is_sweep  = (item_ff.command == CMD_SWEEP);
   assign status.scan_last = (addr_ff == IdxBits'(TABLE_ENTRIES - 1));

   logic [VapBits-1:0] vsel;
   assign vsel = item_ff.vap_index[VapBits-1:0];

   // The slot read in the previous scan cycle is checked against the word.
   logic               scan_eap, scan_sweep, rd_key, rd_expired, rd_vap_ok;
   logic [31:0]        rd_age;
   logic [VapBits-1:0] rd_vsel;
   assign scan_eap   = rd_live_ff && status.is_eap;
   assign scan_sweep = rd_live_ff && status.is_sweep;
   assign rd_key     = rd_valid_ff && rd_ff.vap == item_ff.vap_index
                       && rd_ff.mac == item_ff.station_mac;
   assign rd_age     = item_ff.current_seconds - rd_ff.stamp;
   assign rd_expired = rd_valid_ff && (rd_age > {24'd0, timeout_seconds});
   assign rd_vap_ok  = ({28'd0, rd_ff.vap} < 32'(VAP_COUNT));
   assign rd_vsel    = rd_ff.vap[VapBits-1:0];

   // Decisions for the update step, from the scan results.
   logic               is_resp, is_close, same, have, mem_write;
   logic [IdxBits-1:0] new_slot;
   slot_entry_type     new_entry;
   assign is_resp   = (item_ff.eap_code == CODE_RESPONSE);
   assign is_close  = (item_ff.eap_code == CODE_SUCCESS) || (item_ff.eap_code == CODE_FAILURE);
   assign same      = hit_ff && hit_dir_ff == item_ff.direction && hit_resp_ff == is_resp
                      && hit_ident_ff == item_ff.eap_identifier;
   assign have      = free_ok_ff || hit_ff;
   // The old slot is freed first; if it lies below the first free one, or no slot is free, it is reused.
   assign new_slot  = (hit_ff && (!free_ok_ff || hit_idx_ff < free_idx_ff)) ? hit_idx_ff
                                                                            : free_idx_ff;
   assign mem_write = cmd.update && status.is_eap && !is_close && have;

   always_comb begin
      new_entry.vap         = item_ff.vap_index;
      new_entry.mac         = item_ff.station_mac;
      new_entry.is_response = is_resp;
      new_entry.identifier  = item_ff.eap_identifier;
      new_entry.direction   = item_ff.direction;
      new_entry.stamp       = item_ff.current_seconds;
   end

   // Slot memory: one registered read per scan cycle, one write on update.
   always_ff @(posedge clock) begin
      if (mem_write) begin
         slot_mem[new_slot] <= new_entry;
      end
      if (cmd.scan_step) begin
         rd_ff <= slot_mem[addr_ff];
      end
   end

   // Scan address, read bookkeeping and search results.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan_step;
      end
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.scan_step) begin
         rd_valid_ff <= valid_ff[addr_ff];
         rd_idx_ff   <= addr_ff;
      end
      if (cmd.scan_clear) begin
         addr_ff    <= '0;
         hit_ff     <= 1'b0;
         free_ok_ff <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            addr_ff <= addr_ff + IdxBits'(1);
         end
         if (scan_eap && rd_key && !hit_ff) begin
            hit_ff       <= 1'b1;
            hit_idx_ff   <= rd_idx_ff;
            hit_resp_ff  <= rd_ff.is_response;
            hit_ident_ff <= rd_ff.identifier;
            hit_dir_ff   <= rd_ff.direction;
         end
         if (scan_eap && !rd_valid_ff && !free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   // Next valid bits: expiry during a sweep, freeing and filling on update.
   always_comb begin
      valid_in = valid_ff;
      if (scan_sweep && rd_expired) begin
         valid_in[rd_idx_ff] = 1'b0;
      end
      if (cmd.update && status.is_eap) begin
         if (hit_ff) begin
            valid_in[hit_idx_ff] = 1'b0;
         end
         if (!is_close && have) begin
            valid_in[new_slot] = 1'b1;
         end
      end
   end

   // Valid bits and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int v = 0; v < VAP_COUNT; v++) begin
            succ_ff[v] <= '0;
            fail_ff[v] <= '0;
            tout_ff[v] <= '0;
            rtry_ff[v] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (scan_sweep && rd_expired && rd_vap_ok) begin
            tout_ff[rd_vsel] <= tout_ff[rd_vsel] + COUNTER_BITS'(1);
         end
         if (cmd.update && status.is_eap) begin
            if (is_close) begin
               if (item_ff.eap_code == CODE_SUCCESS) begin
                  succ_ff[vsel] <= succ_ff[vsel] + COUNTER_BITS'(1);
               end else begin
                  fail_ff[vsel] <= fail_ff[vsel] + COUNTER_BITS'(1);
               end
            end else if (same) begin
               rtry_ff[vsel] <= rtry_ff[vsel] + COUNTER_BITS'(1);
            end
         end
      end
   end

   // Per-word flags: retry, dropped entry and sweep count.
   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         retry_ff   <= 1'b0;
         full_ff    <= 1'b0;
         expired_ff <= '0;
      end else begin
         if (scan_sweep && rd_expired && expired_ff != 7'd127) begin
            expired_ff <= expired_ff + 7'd1;
         end
         if (cmd.update && status.is_eap && !is_close) begin
            retry_ff <= same;
            full_ff  <= !have;
         end
      end
   end

   // Result word assembly.
   rsp_word_type report_word;
   always_comb begin
      report_word               = '0;
      if (vap_ok) begin
         report_word.success_count = 32'(succ_ff[vsel]);
         report_word.failure_count = 32'(fail_ff[vsel]);
         report_word.timeout_count = 32'(tout_ff[vsel]);
         report_word.retry_count   = 32'(rtry_ff[vsel]);
      end
      report_word.retry_seen    = retry_ff;
      report_word.table_full    = full_ff;
      report_word.expired_now   = expired_ff;
   end

   // Result word capture, then output register.
   always_ff @(posedge clock) begin
      if (cmd.report) begin
         out_ff <= report_word;
      end
      if (cmd.emit) begin
         rsp_data <= out_ff;
      end
   end
endmodule
